@@ hdl/tpd_pkg.sv @@
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types and constants of the touch pad press detector.
// ----------------------------------------------------------------------------
package tpd_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int CALIB_DEPTH    = 10;
	localparam int CALIB_IDX_BITS = $clog2(CALIB_DEPTH);
	// ten full-scale samples summed never wrap
	localparam int ACC_BITS       = SAMPLE_BITS + $clog2(CALIB_DEPTH);
	localparam int DIV_CNT_BITS   = $clog2(ACC_BITS);
	localparam int REM_BITS       = 3;
	localparam int SCAN_CNT_BITS  = 3;
	localparam int LOCK_BITS      = 2;
	localparam int CFG_IDX_BITS   = 2;

	localparam logic [ACC_BITS-1:0]       DIV_BY           = ACC_BITS'(6);
	localparam logic [SCAN_CNT_BITS-1:0]  GROUP_NORMAL     = 3'd3;
	localparam logic [SCAN_CNT_BITS-1:0]  GROUP_CONTINUOUS = 3'd6;
	localparam logic [LOCK_BITS-1:0]      LOCKOUT_SCANS    = 2'd3;
	localparam logic [SAMPLE_BITS-1:0]    GATE_RESET       = 16'd100;
	localparam logic [CALIB_IDX_BITS-1:0] CALIB_LAST       = CALIB_IDX_BITS'(CALIB_DEPTH - 1);
	localparam logic [1:0]                PASS_LAST        = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_CONTINUOUS = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GATE       = 2'd1;

	localparam logic MODE_CALIB = 1'b0;
	localparam logic MODE_SCAN  = 1'b1;

	localparam logic KIND_CALIB = 1'b0;
	localparam logic KIND_SCAN  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_SEL,
		ST_DROP,
		ST_DIV,
		ST_SCAN_PEAK,
		ST_SCAN_LIMIT,
		ST_SCAN_CMP,
		ST_EMIT
	} tpd_state_t;

	typedef struct packed {
		logic [ACC_BITS-1:0] a;
		logic [ACC_BITS-1:0] b;
		logic                sub;
	} tpd_alu_req_t;

	typedef struct packed {
		logic [ACC_BITS-1:0] y;
		logic                borrow;
	} tpd_alu_rsp_t;

endpackage

@@ hdl/tpd_alu.sv @@
// ----------------------------------------------------------------------------
// tpd_alu
// Shared adder/subtractor; a subtract also serves as a compare by its borrow.
// ----------------------------------------------------------------------------
module tpd_alu import tpd_pkg::*; (
	input  tpd_alu_req_t req,
	output tpd_alu_rsp_t rsp
);

	logic [ACC_BITS:0] full;

	assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{ACC_BITS{1'b0}}, req.sub};

	assign rsp.y      = full[ACC_BITS-1:0];
	// borrow on a subtract means a < b
	assign rsp.borrow = req.sub & ~full[ACC_BITS];

endmodule

@@ hdl/tpd_calib_store.sv @@
// ----------------------------------------------------------------------------
// tpd_calib_store
// Ten-entry store of calibration samples, one write and one read port.
// ----------------------------------------------------------------------------
module tpd_calib_store import tpd_pkg::*; (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [CALIB_IDX_BITS-1:0] wr_idx,
	input  logic [SAMPLE_BITS-1:0]    wr_data,
	input  logic [CALIB_IDX_BITS-1:0] rd_idx,
	output logic [SAMPLE_BITS-1:0]    rd_data
);

	logic [SAMPLE_BITS-1:0] mem_q [CALIB_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_idx];

endmodule

@@ hdl/touch_pad_press_detector.sv @@
// ----------------------------------------------------------------------------
// touch_pad_press_detector
// Baseline calibration and press decision for one capacitive touch pad.
// ----------------------------------------------------------------------------
// One word is taken at a time; item_stall is high while a word is being worked
// on. A calibration word that does not complete a round of ten is stored
// while the engine stays idle. The tenth one starts the baseline run on the
// shared adder/subtractor: a sum of the ten samples, four selection passes
// (each a read of the ten samples and a drop step) that find and drop the
// two smallest and two largest samples, and 20 restoring divide steps for
// the floor division by six before the result is offered. A scan word runs
// the peak update, and when it closes a group also baseline plus gate,
// compare and result load.
// The result register frees the engine: the next word is taken while a
// result still waits on result_stall, and the engine only holds when a new
// result is ready and the previous one has not been taken yet.
// Configuration writes are taken every cycle; index 0 is continuous_mode,
// index 1 is touch_gate, other indexes are dropped.
// ----------------------------------------------------------------------------
module touch_pad_press_detector import tpd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// input word channel
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    mode,
	input  logic [SAMPLE_BITS-1:0]  sample,
	// result word channel
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    result_kind,
	output logic                    pressed,
	output logic [SAMPLE_BITS-1:0]  group_peak,
	output logic [SAMPLE_BITS-1:0]  baseline_value,
	output logic                    calib_fault,
	// configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [SAMPLE_BITS-1:0]  cfg_data
);

	tpd_state_t state_q, state_d;

	// configuration
	logic                   cont_q;
	logic [SAMPLE_BITS-1:0] gate_q;

	// architectural state
	logic [CALIB_IDX_BITS-1:0] calib_cnt_q;
	logic [SAMPLE_BITS-1:0]    baseline_q;
	logic [SCAN_CNT_BITS-1:0]  scan_cnt_q;
	logic [SAMPLE_BITS-1:0]    peak_q;
	logic [LOCK_BITS-1:0]      lock_q;

	// working registers of the sequencer
	logic [SAMPLE_BITS-1:0]    samp_q;
	logic [CALIB_IDX_BITS-1:0] idx_q;
	logic [1:0]                pass_q;
	logic [ACC_BITS-1:0]       acc_q;
	logic [SAMPLE_BITS-1:0]    best_q;
	logic [CALIB_IDX_BITS-1:0] best_idx_q;
	logic                      have_q;
	logic [CALIB_DEPTH-1:0]    excl_q;
	logic [REM_BITS-1:0]       rem_q;
	logic [DIV_CNT_BITS-1:0]   div_cnt_q;
	logic [SAMPLE_BITS:0]      limit_q;

	// pending result
	logic                   pend_kind_q;
	logic                   pend_pressed_q;
	logic [SAMPLE_BITS-1:0] pend_peak_q;

	// result register
	logic                   res_valid_q;
	logic                   res_kind_q;
	logic                   res_pressed_q;
	logic [SAMPLE_BITS-1:0] res_peak_q;
	logic [SAMPLE_BITS-1:0] res_base_q;

	logic                   item_acc;
	logic                   store_wr;
	logic [SAMPLE_BITS-1:0] store_rd;
	tpd_alu_req_t           alu_req;
	tpd_alu_rsp_t           alu_rsp;
	logic                   res_free;
	logic                   res_load;

	logic [REM_BITS:0]         trial;
	logic                      div_fits;
	logic [SCAN_CNT_BITS-1:0]  scan_cnt_inc;
	logic [SCAN_CNT_BITS-1:0]  group_size;
	logic [SAMPLE_BITS-1:0]    peak_new;
	logic                      sel_better;
	logic [LOCK_BITS-1:0]      lock_eff;

	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid & ~item_stall;
	assign store_wr   = item_acc & (mode == MODE_CALIB);
	assign cfg_ready  = 1'b1;

	tpd_calib_store u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_idx  (calib_cnt_q),
		.wr_data (sample),
		.rd_idx  (idx_q),
		.rd_data (store_rd)
	);

	tpd_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// divide step: shift the next dividend bit into the remainder
	assign trial    = {rem_q, acc_q[ACC_BITS-1]};
	assign div_fits = ~alu_rsp.borrow;

	assign scan_cnt_inc = scan_cnt_q + 3'd1;
	assign group_size   = cont_q ? GROUP_CONTINUOUS : GROUP_NORMAL;
	assign peak_new     = alu_rsp.borrow ? samp_q : peak_q;
	// min passes first, then max passes; the compare order flips between them
	assign sel_better   = alu_rsp.borrow;
	assign lock_eff     = cont_q ? '0 : lock_q;

	assign res_free = ~res_valid_q | ~result_stall;
	assign res_load = (state_q == ST_EMIT) & res_free;

	// sequencer: next state and the operation of the shared unit
	always_comb begin
		state_d     = state_q;
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (mode == MODE_SCAN) begin
						state_d = ST_SCAN_PEAK;
					end else if (calib_cnt_q == CALIB_LAST) begin
						state_d = ST_SUM;
					end
				end
			end
			ST_SUM: begin
				alu_req.a = acc_q;
				alu_req.b = ACC_BITS'(store_rd);
				if (idx_q == CALIB_LAST) begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				alu_req.sub = 1'b1;
				if (pass_q[1]) begin
					alu_req.a = ACC_BITS'(best_q);
					alu_req.b = ACC_BITS'(store_rd);
				end else begin
					alu_req.a = ACC_BITS'(store_rd);
					alu_req.b = ACC_BITS'(best_q);
				end
				if (idx_q == CALIB_LAST) begin
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				alu_req.a   = acc_q;
				alu_req.b   = ACC_BITS'(best_q);
				alu_req.sub = 1'b1;
				state_d     = (pass_q == PASS_LAST) ? ST_DIV : ST_SEL;
			end
			ST_DIV: begin
				alu_req.a   = ACC_BITS'(trial);
				alu_req.b   = DIV_BY;
				alu_req.sub = 1'b1;
				if (div_cnt_q == DIV_CNT_BITS'(ACC_BITS - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_SCAN_PEAK: begin
				alu_req.a   = ACC_BITS'(peak_q);
				alu_req.b   = ACC_BITS'(samp_q);
				alu_req.sub = 1'b1;
				state_d     = (scan_cnt_inc >= group_size) ? ST_SCAN_LIMIT : ST_IDLE;
			end
			ST_SCAN_LIMIT: begin
				// baseline plus gate, kept one bit wider so it never wraps
				alu_req.a = ACC_BITS'(baseline_q);
				alu_req.b = ACC_BITS'(gate_q);
				state_d   = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				alu_req.a   = ACC_BITS'(limit_q);
				alu_req.b   = ACC_BITS'(pend_peak_q);
				alu_req.sub = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_q <= 1'b0;
			gate_q <= GATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CONTINUOUS: cont_q <= cfg_data[0];
				CFG_GATE:       gate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_cnt_q    <= '0;
			baseline_q     <= '0;
			scan_cnt_q     <= '0;
			peak_q         <= '0;
			lock_q         <= '0;
			samp_q         <= '0;
			idx_q          <= '0;
			pass_q         <= '0;
			acc_q          <= '0;
			best_q         <= '0;
			best_idx_q     <= '0;
			have_q         <= 1'b0;
			excl_q         <= '0;
			rem_q          <= '0;
			div_cnt_q      <= '0;
			limit_q        <= '0;
			pend_kind_q    <= KIND_CALIB;
			pend_pressed_q <= 1'b0;
			pend_peak_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						samp_q <= sample;
						if (mode == MODE_CALIB) begin
							if (calib_cnt_q == CALIB_LAST) begin
								// round complete: start the baseline run
								calib_cnt_q <= '0;
								acc_q       <= '0;
								idx_q       <= '0;
							end else begin
								calib_cnt_q <= calib_cnt_q + 1'b1;
							end
						end
					end
				end
				ST_SUM: begin
					acc_q <= alu_rsp.y;
					if (idx_q == CALIB_LAST) begin
						idx_q  <= '0;
						pass_q <= '0;
						have_q <= 1'b0;
						excl_q <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SEL: begin
					// keep the first extreme found, so equal values drop one at a time
					if (!excl_q[idx_q] && (!have_q || sel_better)) begin
						best_q     <= store_rd;
						best_idx_q <= idx_q;
						have_q     <= 1'b1;
					end
					idx_q <= (idx_q == CALIB_LAST) ? '0 : idx_q + 1'b1;
				end
				ST_DROP: begin
					acc_q              <= alu_rsp.y;
					excl_q[best_idx_q] <= 1'b1;
					have_q             <= 1'b0;
					pass_q             <= pass_q + 1'b1;
					rem_q              <= '0;
					div_cnt_q          <= '0;
				end
				ST_DIV: begin
					rem_q     <= div_fits ? alu_rsp.y[REM_BITS-1:0] : trial[REM_BITS-1:0];
					acc_q     <= {acc_q[ACC_BITS-2:0], div_fits};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_BITS'(ACC_BITS - 1)) begin
						baseline_q     <= {acc_q[SAMPLE_BITS-2:0], div_fits};
						pend_kind_q    <= KIND_CALIB;
						pend_pressed_q <= 1'b0;
						pend_peak_q    <= '0;
					end
				end
				ST_SCAN_PEAK: begin
					if (scan_cnt_inc >= group_size) begin
						pend_peak_q <= peak_new;
						peak_q      <= '0;
						scan_cnt_q  <= '0;
					end else begin
						peak_q     <= peak_new;
						scan_cnt_q <= scan_cnt_inc;
					end
				end
				ST_SCAN_LIMIT: begin
					limit_q <= alu_rsp.y[SAMPLE_BITS:0];
				end
				ST_SCAN_CMP: begin
					pend_kind_q <= KIND_SCAN;
					if (alu_rsp.borrow) begin
						// touched: report only past the lockout, then reload it
						pend_pressed_q <= (lock_eff == '0);
						lock_q         <= LOCKOUT_SCANS - 1'b1;
					end else begin
						pend_pressed_q <= 1'b0;
						lock_q         <= (lock_eff != '0) ? lock_eff - 1'b1 : '0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q   <= 1'b0;
			res_kind_q    <= KIND_CALIB;
			res_pressed_q <= 1'b0;
			res_peak_q    <= '0;
			res_base_q    <= '0;
		end else if (res_load) begin
			res_valid_q   <= 1'b1;
			res_kind_q    <= pend_kind_q;
			res_pressed_q <= pend_pressed_q;
			res_peak_q    <= pend_peak_q;
			res_base_q    <= baseline_q;
		end else if (res_valid_q && !result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result_valid   = res_valid_q;
	assign result_kind    = res_kind_q;
	assign pressed        = res_pressed_q;
	assign group_peak     = res_peak_q;
	assign baseline_value = res_base_q;
	// fault when the baseline reaches half of full scale
	assign calib_fault    = res_base_q[SAMPLE_BITS-1];

endmodule

@@ hdl/tpd_checker.sv @@
// ----------------------------------------------------------------------------
// tpd_checker
// Port-level checks of the touch pad press detector, bound to the top level.
// ----------------------------------------------------------------------------
module tpd_checker import tpd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_valid,
	input logic                    item_stall,
	input logic                    mode,
	input logic                    result_valid,
	input logic                    result_stall,
	input logic                    result_kind,
	input logic                    pressed,
	input logic [SAMPLE_BITS-1:0]  group_peak,
	input logic [SAMPLE_BITS-1:0]  baseline_value,
	input logic                    calib_fault
);

	// hold a stalled result word
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(group_peak)
			&& $stable(baseline_value) && $stable(result_kind) && $stable(pressed))
		else $error("stalled result word changed");

	// a calibration word carries no press and no peak
	a_calib_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_kind == KIND_CALIB |-> !pressed && group_peak == '0)
		else $error("calibration word with press or peak");

	// the fault flag follows the reported baseline
	a_fault_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> calib_fault == baseline_value[SAMPLE_BITS-1])
		else $error("fault flag disagrees with baseline");

	// a scan word always occupies the engine for the next cycle
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && mode == MODE_SCAN |=> item_stall)
		else $error("scan word did not hold the engine");

endmodule

bind touch_pad_press_detector tpd_checker u_tpd_checker (.*);
